// ----- rtl/rbe_pkg.sv -----
// Shared types and constants for the byte-wise rANS encoder.
package rbe_pkg;

   localparam int SCALE_BITS_DEF = 16;
   localparam int STATE_W       = 32;
   localparam int FREQ_W        = 16;
   localparam int BYTE_W        = 8;
   localparam int FLUSH_BYTES   = 4;
   localparam logic [STATE_W-1:0] RANS_LOW = 32'h0080_0000;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [FREQ_W-1:0] sym_freq;
      logic [FREQ_W-1:0] sym_cum;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic emit_renorm;
      logic div_init;
      logic div_step;
      logic commit;
      logic emit_flush;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_flush;
      logic freq_zero;
      logic renorm_need;
      logic div_last;
      logic flush_last;
      logic out_free;
   } sts_type;

endpackage

// ----- rtl/rbe_ctrl.sv -----
// Sequencer for the rANS encoder: accept, renormalize, divide, commit, flush.
module rbe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rbe_pkg::sts_type sts,
   output rbe_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_RENORM = 3'd2;
   localparam logic [2:0] S_DIVIDE = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;
   localparam logic [2:0] S_FLUSH  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (sts.is_flush) begin
               state_in = S_FLUSH;
            end else if (sts.freq_zero) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_RENORM;
            end
         end
         S_RENORM: begin
            if (sts.renorm_need) begin
               cmd.emit_renorm = sts.out_free;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         S_FLUSH: begin
            if (sts.out_free) begin
               cmd.emit_flush = 1'b1;
               if (sts.flush_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/rbe_dpath.sv -----
// Datapath: coder state, renormalization shifter, radix-2 divider, output register.
module rbe_dpath #(
   parameter int SCALE_BITS = rbe_pkg::SCALE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  rbe_pkg::req_type req_data,
   input  rbe_pkg::cmd_type cmd,
   output rbe_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rbe_pkg::rsp_type rsp_data
);

   localparam int SW    = rbe_pkg::STATE_W;
   localparam int FW    = rbe_pkg::FREQ_W;
   localparam int BW    = rbe_pkg::BYTE_W;
   localparam int QB    = 31 - SCALE_BITS;             // quotient bits
   localparam int XW    = (FW + QB > SW) ? FW + QB : SW;
   localparam int CNT_W = $clog2(QB + 1);
   localparam int SUM_W = SW + 1;

   logic [SW-1:0]    coder_state_ff, coder_state_in;
   logic [SW-1:0]    work_ff, work_in;
   logic             op_ff, op_in;
   logic [FW-1:0]    freq_ff, freq_in;
   logic [FW-1:0]    cum_ff, cum_in;
   logic [FW-1:0]    rem_ff, rem_in;
   logic [QB-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rbe_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [XW-1:0]    x_max;
   logic [FW:0]      trial;
   logic             trial_ge;
   logic [FW:0]      trial_diff;
   logic [SUM_W-1:0] next_sum;
   logic             out_free;

   assign x_max      = XW'({freq_ff, {QB{1'b0}}});
   assign trial      = {rem_ff, work_ff[QB-1]};
   assign trial_ge   = (trial >= {1'b0, freq_ff});
   assign trial_diff = trial - {1'b0, freq_ff};
   assign next_sum   = SUM_W'({quo_ff, {SCALE_BITS{1'b0}}}) + SUM_W'(cum_ff) + SUM_W'(rem_ff);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign sts.is_flush    = (op_ff == rbe_pkg::OP_FLUSH);
   assign sts.freq_zero   = (freq_ff == '0);
   assign sts.renorm_need = (XW'(work_ff) >= x_max);
   assign sts.div_last    = (cnt_ff == CNT_W'(QB - 1));
   assign sts.flush_last  = (cnt_ff == CNT_W'(rbe_pkg::FLUSH_BYTES - 1));
   assign sts.out_free    = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      coder_state_in = coder_state_ff;
      work_in        = work_ff;
      op_in          = op_ff;
      freq_in        = freq_ff;
      cum_in         = cum_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load) begin
         work_in = coder_state_ff;
         op_in   = req_data.operation;
         freq_in = req_data.sym_freq;
         cum_in  = req_data.sym_cum;
         cnt_in  = '0;
      end

      if (cmd.emit_renorm || cmd.emit_flush) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.out_byte = work_ff[BW-1:0];
         rsp_data_in.last     = cmd.emit_flush && sts.flush_last;
         work_in              = work_ff >> BW;
      end

      if (cmd.emit_flush) begin
         cnt_in = cnt_ff + 1'b1;
         if (sts.flush_last) begin
            coder_state_in = rbe_pkg::RANS_LOW;
         end
      end

      // state is below freq << QB here, so the top part is already < freq
      if (cmd.div_init) begin
         rem_in = FW'(work_ff >> QB);
         cnt_in = '0;
      end

      if (cmd.div_step) begin
         rem_in  = trial_ge ? trial_diff[FW-1:0] : trial[FW-1:0];
         quo_in  = {quo_ff[QB-2:0], trial_ge};
         work_in = work_ff << 1;
         cnt_in  = cnt_ff + 1'b1;
      end

      if (cmd.commit) begin
         coder_state_in = next_sum[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coder_state_ff <= rbe_pkg::RANS_LOW;
         rsp_valid_ff   <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         coder_state_ff <= coder_state_in;
         rsp_valid_ff   <= rsp_valid_in;
         cnt_ff         <= cnt_in;
      end
      work_ff     <= work_in;
      op_ff       <= op_in;
      freq_ff     <= freq_in;
      cum_ff      <= cum_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- rtl/rans_byte_encoder.sv -----
// Top level of the byte-wise rANS encoder with a 32-bit coder state.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    rbe_pkg::req_type (operation, sym_freq, sym_cum)
//   rsp      out  rsp_valid/rsp_ready    rbe_pkg::rsp_type (out_byte, last)
//
// One item at a time. Encode: accept, decide, k renorm beats (k = 0..3 at
// SCALE_BITS = 16), then the restoring divider takes one quotient bit a cycle,
// then commit. Flush: four byte beats, one per cycle while rsp is free. Zero
// frequency: no output and no state change. Reset puts the coder state at 2^23.
// A stalled rsp holds the byte loop; req_ready stays low until commit or a flush's last beat.
module rans_byte_encoder #(
   parameter int SCALE_BITS = rbe_pkg::SCALE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rbe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rbe_pkg::rsp_type rsp_data
);

   rbe_pkg::cmd_type cmd;
   rbe_pkg::sts_type sts;

   rbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rbe_dpath #(
      .SCALE_BITS (SCALE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a second item while busy");

   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_renorm || cmd.emit_flush) |-> sts.out_free)
      else $error("byte beat issued with output register full");

   a_commit_frees: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> req_ready)
      else $error("not ready after state commit");

   a_single_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.emit_renorm, cmd.div_init, cmd.div_step,
                cmd.commit, cmd.emit_flush}))
      else $error("conflicting datapath commands");

endmodule
